[hdl/sawars_pkg.sv]
// Shared types and constants for the stop-and-wait ack/retry sender.
// No dependencies; imported by the sender and its checker.
package sawars_pkg;

  localparam int unsigned MaxFrame   = 250;
  localparam logic [15:0] NoAckWait  = 16'd25;
  localparam logic [8:0]  HdrBytes   = 9'd10;
  localparam logic [8:0]  PadMask    = 9'h00F;

  typedef enum logic [1:0] {
    KIND_SEND = 2'd0,
    KIND_SENT = 2'd1,
    KIND_RESP = 2'd2,
    KIND_TICK = 2'd3
  } in_kind_e;

  typedef enum logic {
    OUT_TX   = 1'b0,
    OUT_DONE = 1'b1
  } out_kind_e;

  typedef enum logic [1:0] {
    ST_ACKED  = 2'd0,
    ST_GAVEUP = 2'd1,
    ST_OTA    = 2'd2,
    ST_NOACK  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CFG_ACK_REQUIRED = 3'd0,
    CFG_ENCRYPT_MODE = 3'd1,
    CFG_ACK_MAGIC    = 3'd2,
    CFG_OTA_MAGIC    = 3'd3,
    CFG_OTA_ENABLE   = 3'd4,
    CFG_RETRY_TMO    = 3'd5,
    CFG_MAX_RETRIES  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    in_kind_e    kind;
    logic [7:0]  payload_len;
    logic        resp_len_ok;
    logic [15:0] resp_magic;
    logic [15:0] resp_seq;
  } in_beat_t;

  typedef struct packed {
    out_kind_e   out_kind;
    logic [7:0]  seq_out;
    logic [7:0]  retry_out;
    logic [8:0]  frame_len;
    logic        size_error;
    status_e     status;
    logic [31:0] fail_count;
    logic [31:0] total_fail_count;
  } out_beat_t;

endpackage

[hdl/stop_and_wait_ack_retry_sender.sv]
// Stop-and-wait ack/retry sender: one event beat in, at most one result beat out.
// A result is registered: it appears in the output register in the cycle after its event beat.
// Throughput: one event per cycle; the only hold-off is a full output register
// that the downstream side stalls. Reset (async, active low) clears all protocol
// state and counters and loads the configuration defaults.
// Depends on sawars_pkg.
module stop_and_wait_ack_retry_sender
  import sawars_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // event channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_beat_t    in_beat_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_beat_t   out_beat_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic        ack_required_q, encrypt_mode_q, ota_enable_q;
  logic [15:0] ack_magic_q, ota_magic_q, retry_tmo_q;
  logic [7:0]  max_retries_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_required_q <= 1'b1;
      encrypt_mode_q <= 1'b1;
      ack_magic_q    <= '0;
      ota_magic_q    <= '0;
      ota_enable_q   <= 1'b0;
      retry_tmo_q    <= 16'd100;
      max_retries_q  <= 8'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ACK_REQUIRED: ack_required_q <= cfg_data_i[0];
        CFG_ENCRYPT_MODE: encrypt_mode_q <= cfg_data_i[0];
        CFG_ACK_MAGIC:    ack_magic_q    <= cfg_data_i;
        CFG_OTA_MAGIC:    ota_magic_q    <= cfg_data_i;
        CFG_OTA_ENABLE:   ota_enable_q   <= cfg_data_i[0];
        CFG_RETRY_TMO:    retry_tmo_q    <= cfg_data_i;
        CFG_MAX_RETRIES:  max_retries_q  <= cfg_data_i[7:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Protocol state
  // ---------------------------------------------------------------------------
  logic [7:0]  seq_q, seq_d;          // next sequence to expect in an ack
  logic [7:0]  msg_seq_q, msg_seq_d;  // sequence stamped on the message in flight
  logic [1:0]  progress_q, progress_d;  // sent notice + ack, saturates at 3
  logic        busy_q, busy_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [7:0]  retry_q, retry_d;
  logic [8:0]  frame_len_q, frame_len_d;
  logic        ota_flag_q, ota_flag_d;
  logic [31:0] cons_fails_q, cons_fails_d;
  logic [31:0] all_fails_q, all_fails_d;

  logic        out_valid_q, out_valid_d;
  out_beat_t   out_beat_q, out_beat_d;

  logic        in_accept;
  logic        emit;
  out_kind_e   emit_kind;
  status_e     emit_status;

  // The output register may be refilled in the cycle its beat is taken.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  // Frame length: in encrypt mode the payload is padded up to a multiple of
  // 16 bytes and the header is added; at most 256 + 10, fits 9 bits.
  logic [8:0] frame_len_new;
  always_comb begin
    if (encrypt_mode_q) begin
      frame_len_new = (({1'b0, in_beat_i.payload_len} + PadMask) & ~PadMask) + HdrBytes;
    end else begin
      frame_len_new = {1'b0, in_beat_i.payload_len};
    end
  end

  logic [15:0] elapsed_inc;
  logic [7:0]  retry_inc;
  logic [1:0]  progress_inc;
  logic        ack_match;
  logic        ota_match;

  assign elapsed_inc  = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
  assign retry_inc    = (retry_q == 8'hFF) ? retry_q : retry_q + 8'd1;
  assign progress_inc = (progress_q == 2'd3) ? progress_q : progress_q + 2'd1;
  assign ota_match    = ota_enable_q && (in_beat_i.resp_magic == ota_magic_q);
  assign ack_match    = (in_beat_i.resp_magic == ack_magic_q) &&
                        (in_beat_i.resp_seq == {8'd0, seq_q});

  // Event handling. Counters in the result are the values after the event.
  always_comb begin
    seq_d        = seq_q;
    msg_seq_d    = msg_seq_q;
    progress_d   = progress_q;
    busy_d       = busy_q;
    elapsed_d    = elapsed_q;
    retry_d      = retry_q;
    frame_len_d  = frame_len_q;
    ota_flag_d   = ota_flag_q;
    cons_fails_d = cons_fails_q;
    all_fails_d  = all_fails_q;
    emit         = 1'b0;
    emit_kind    = OUT_TX;
    emit_status  = ST_ACKED;

    if (in_accept) begin
      unique case (in_beat_i.kind)
        KIND_SEND: begin
          // a send while busy drops the old message
          frame_len_d = frame_len_new;
          msg_seq_d   = seq_q;
          retry_d     = '0;
          progress_d  = '0;
          elapsed_d   = '0;
          busy_d      = 1'b1;
          emit        = 1'b1;
        end
        KIND_SENT: begin
          progress_d = progress_inc;
        end
        KIND_RESP: begin
          if (in_beat_i.resp_len_ok) begin
            if (ota_match) begin
              ota_flag_d = 1'b1;
            end else if (ack_match) begin
              progress_d = progress_inc;
              seq_d      = seq_q + 8'd1;
            end
          end
        end
        KIND_TICK: begin
          if (busy_q) begin
            elapsed_d = elapsed_inc;
            priority if (!ack_required_q) begin
              if (progress_q != 2'd0 || elapsed_inc > NoAckWait) begin
                busy_d      = 1'b0;
                emit        = 1'b1;
                emit_kind   = OUT_DONE;
                emit_status = ST_NOACK;
              end
            end else if (progress_q[1]) begin
              cons_fails_d = '0;
              busy_d       = 1'b0;
              emit         = 1'b1;
              emit_kind    = OUT_DONE;
              emit_status  = ST_ACKED;
            end else if (ota_enable_q && ota_flag_q) begin
              busy_d      = 1'b0;
              emit        = 1'b1;
              emit_kind   = OUT_DONE;
              emit_status = ST_OTA;
            end else if (elapsed_inc > retry_tmo_q) begin
              retry_d = retry_inc;
              emit    = 1'b1;
              if (retry_inc >= max_retries_q) begin
                // give up on this message
                seq_d        = seq_q + 8'd1;
                cons_fails_d = (cons_fails_q == '1) ? cons_fails_q : cons_fails_q + 32'd1;
                all_fails_d  = (all_fails_q == '1) ? all_fails_q : all_fails_q + 32'd1;
                busy_d       = 1'b0;
                emit_kind    = OUT_DONE;
                emit_status  = ST_GAVEUP;
              end else begin
                // retransmit
                progress_d = '0;
                elapsed_d  = '0;
              end
            end else begin
              emit = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result beat built from the post-event state.
  always_comb begin
    out_beat_d.out_kind         = emit_kind;
    out_beat_d.seq_out          = msg_seq_d;
    out_beat_d.retry_out        = retry_d;
    out_beat_d.frame_len        = frame_len_d;
    out_beat_d.size_error       = ({1'b0, frame_len_d} > 10'(MaxFrame));
    out_beat_d.status           = emit_status;
    out_beat_d.fail_count       = cons_fails_d;
    out_beat_d.total_fail_count = all_fails_d;
  end

  always_comb begin
    if (in_accept) begin
      out_valid_d = emit;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q        <= '0;
      msg_seq_q    <= '0;
      progress_q   <= '0;
      busy_q       <= 1'b0;
      elapsed_q    <= '0;
      retry_q      <= '0;
      frame_len_q  <= '0;
      ota_flag_q   <= 1'b0;
      cons_fails_q <= '0;
      all_fails_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      seq_q        <= seq_d;
      msg_seq_q    <= msg_seq_d;
      progress_q   <= progress_d;
      busy_q       <= busy_d;
      elapsed_q    <= elapsed_d;
      retry_q      <= retry_d;
      frame_len_q  <= frame_len_d;
      ota_flag_q   <= ota_flag_d;
      cons_fails_q <= cons_fails_d;
      all_fails_q  <= all_fails_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload register, loaded only with a fresh beat
  always_ff @(posedge clk_i) begin
    if (in_accept && emit) begin
      out_beat_q <= out_beat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

[hdl/sawars_chk.sv]
// Port-level checker for the stop-and-wait sender, bound to the top level.
// Depends on sawars_pkg and stop_and_wait_ack_retry_sender.
module sawars_chk
  import sawars_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_beat_t  in_beat_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_beat_t out_beat_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // stalled result beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat_o))
    else $error("result beat changed while stalled");

  // every send request gives a transmit beat next cycle
  a_send_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_beat_i.kind == KIND_SEND |=> out_valid_o && out_beat_o.out_kind == OUT_TX)
    else $error("send request without transmit beat");

  // notices and responses never produce a result
  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_beat_i.kind == KIND_SENT || in_beat_i.kind == KIND_RESP) |=> !out_valid_o)
    else $error("result beat after notice or response");

  // acknowledged completion clears the consecutive fail count
  a_ack_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.out_kind == OUT_DONE && out_beat_o.status == ST_ACKED
      |-> out_beat_o.fail_count == '0)
    else $error("acked completion with nonzero fail count");

  // consecutive fails never exceed all fails
  a_fail_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_beat_o.total_fail_count >= out_beat_o.fail_count)
    else $error("fail counters out of order");

endmodule

bind stop_and_wait_ack_retry_sender sawars_chk u_sawars_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_beat_i   (in_beat_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_beat_o  (out_beat_o)
);
